// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the zero-run packet encoder, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/zrpe_pkg.sv -----
// Types and constants shared by the zero-run packet encoder modules.
package zrpe_pkg;

    localparam int HEADER_BYTES = 6;
    localparam int HDR_W        = 3;
    localparam int NET_W        = 14;

    localparam logic [HDR_W-1:0]        HDR_RESET       = HDR_W'(HEADER_BYTES);
    localparam logic [7:0]              RUN_CLOSE_LIMIT = 8'd254;
    localparam logic [7:0]              ZERO_FLAG_BIT   = 8'h80;
    localparam logic signed [NET_W-1:0] NET_MAX         = 14'sd4096;
    localparam logic signed [NET_W-1:0] NET_MIN         = -14'sd4096;

    // One output word.
    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    out_last;
        logic                    use_encoded;
        logic signed [NET_W-1:0] size_change;
        logic [7:0]              flagged_first_byte;
    } result_t;

    // Per-packet coder state.
    typedef struct packed {
        logic [7:0]              run;
        logic signed [NET_W-1:0] net;
        logic [HDR_W-1:0]        hdr_left;
        logic [7:0]              first;
        logic                    coding;
    } enc_state_t;

    // What one input byte produces.
    typedef struct packed {
        logic [1:0] n;
        result_t    res_a;
        result_t    res_b;
        enc_state_t nxt;
    } step_t;

endpackage

// ----- rtl/zrpe_step.sv -----
// Combinational coding step: one input byte to up to two output words.
module zrpe_step (
    input  zrpe_pkg::enc_state_t st,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 cfg_enable,
    output zrpe_pkg::step_t      step
);
    import zrpe_pkg::*;

    always_comb
    begin : step_calc
        logic       is_first;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [1:0] n;
        logic [7:0] run_inc;
        logic signed [NET_W-1:0] sc;
        enc_state_t nx;

        is_first = (st.hdr_left == HDR_RESET);
        nx       = st;
        if (is_first)
        begin
            nx.first  = in_byte;
            nx.coding = cfg_enable;
        end
        byte_a  = in_byte;
        byte_b  = in_byte;
        n       = 2'd0;
        run_inc = st.run + 8'd1;

        if (st.hdr_left != '0)
        begin
            n           = 2'd1;
            nx.hdr_left = st.hdr_left - HDR_W'(1);
        end
        else if (!nx.coding)
        begin
            n = 2'd1;
        end
        else if (in_byte == 8'd0)
        begin
            if (st.run != 8'd0)
            begin
                if (run_inc > RUN_CLOSE_LIMIT)
                begin
                    byte_a = run_inc;
                    n      = 2'd1;
                    nx.run = 8'd0;
                end
                else
                begin
                    nx.run = run_inc;
                end
                if (st.net != NET_MIN)
                    nx.net = st.net - 14'sd1;
            end
            else
            begin
                byte_a = 8'd0;
                n      = 2'd1;
                nx.run = 8'd1;
                if (st.net != NET_MAX)
                    nx.net = st.net + 14'sd1;
            end
        end
        else
        begin
            if (st.run != 8'd0)
            begin
                byte_a = st.run;
                byte_b = in_byte;
                n      = 2'd2;
                nx.run = 8'd0;
            end
            else
            begin
                n = 2'd1;
            end
        end

        // open run closes on the packet's final byte
        if (in_last && nx.coding && nx.run != 8'd0)
        begin
            if (n == 2'd0)
            begin
                byte_a = nx.run;
                n      = 2'd1;
            end
            else
            begin
                byte_b = nx.run;
                n      = 2'd2;
            end
        end

        sc = nx.coding ? nx.net : '0;

        step.n     = n;
        step.res_a = '{out_byte: byte_a, out_last: 1'b0, use_encoded: 1'b0,
                       size_change: '0, flagged_first_byte: 8'd0};
        step.res_b = '{out_byte: byte_b, out_last: 1'b0, use_encoded: 1'b0,
                       size_change: '0, flagged_first_byte: 8'd0};
        if (in_last)
        begin
            if (n == 2'd2)
            begin
                step.res_b.out_last           = 1'b1;
                step.res_b.use_encoded        = sc < 0;
                step.res_b.size_change        = sc;
                step.res_b.flagged_first_byte = nx.first | ZERO_FLAG_BIT;
            end
            else
            begin
                step.res_a.out_last           = 1'b1;
                step.res_a.use_encoded        = sc < 0;
                step.res_a.size_change        = sc;
                step.res_a.flagged_first_byte = nx.first | ZERO_FLAG_BIT;
            end
            nx.run      = 8'd0;
            nx.net      = '0;
            nx.hdr_left = HDR_RESET;
        end
        step.nxt = nx;
    end

endmodule

// ----- rtl/zrpe_outq.sv -----
// Two-entry output word queue; takes one or two words per push.
module zrpe_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  zrpe_pkg::result_t push_a,
    input  zrpe_pkg::result_t push_b,
    output logic              q_valid,
    output zrpe_pkg::result_t q_data,
    input  logic              q_ready,
    output logic [1:0]        q_count
);
    import zrpe_pkg::*;

    result_t    slot_reg [2];
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign q_valid = count_reg != 2'd0;
    assign q_data  = slot_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push_n[0];
        count_next  = count_reg - {1'b0, pop} + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // two words only land when the queue is empty after this cycle's pop,
    // so both slots are free
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            slot_reg[wr_ptr_reg] <= push_a;
        if (push_n == 2'd2)
            slot_reg[~wr_ptr_reg] <= push_b;
    end

endmodule

// ----- rtl/zero_run_packet_encoder.sv -----
// Zero-run packet encoder top level: input stage, coding step, output queue.
// One packet byte per input word, tlast on the packet's final byte. The first
// six bytes (header) pass unchanged; after that, with coding enabled, each run
// of zero bytes leaves as a 0 word followed by a count word, a run reaching 255
// is closed at once, and other bytes pass after the count of any open run. The
// final output word (tlast) carries use_encoded, the signed size change and the
// first header byte with bit 7 set; on other words those fields are zero.
// The coding enable register is sampled on a packet's first byte and holds for the packet.
// Timing: an accepted word is registered in the input stage, then the coding
// step writes its output words into a two-entry queue that drives the master
// side. A byte producing one output word (or none) moves on every cycle while
// the queue has room for its words; a byte producing two (count then data, or
// 0 then count at packet end) waits until the queue holds at most one word
// that leaves in the same cycle. The queue size sets that rate.
`include "assert_macros.svh"

module zero_run_packet_encoder (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_we,
    input  logic        cfg_wdata,       // zero_coding_enabled
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tlast,    // in_last
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] out_byte, [21:8] size_change,
                                         // [29:22] flagged_first_byte, [31:30] zero
    output logic        m_axis_tlast,    // out_last
    output logic        m_axis_tuser     // use_encoded
);
    import zrpe_pkg::*;

    logic       enable_reg;
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_last_reg;
    enc_state_t state_reg;
    step_t      step;
    logic       fire;
    logic       s_accept;
    logic       m_pop;
    logic [1:0] push_n;
    logic [1:0] q_count;
    result_t    q_data;

    zrpe_step u_step (
        .st         (state_reg),
        .in_byte    (stg_byte_reg),
        .in_last    (stg_last_reg),
        .cfg_enable (enable_reg),
        .step       (step)
    );

    // step may retire only when the queue has room for all its words,
    // counting the word that leaves in this cycle
    assign m_pop         = m_axis_tvalid && m_axis_tready;
    assign fire          = stg_valid_reg &&
                           (({1'b0, step.n} + {1'b0, q_count}) <= (3'd2 + {2'b00, m_pop}));
    assign s_axis_tready = !stg_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign push_n        = fire ? step.n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else if (cfg_we)
            enable_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (s_accept)
            stg_valid_reg <= 1'b1;
        else if (fire)
            stg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            stg_byte_reg <= s_axis_tdata;
            stg_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{run: 8'd0, net: '0, hdr_left: HDR_RESET, first: 8'd0,
                           coding: 1'b0};
        else if (fire)
            state_reg <= step.nxt;
    end

    zrpe_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_n  (push_n),
        .push_a  (step.res_a),
        .push_b  (step.res_b),
        .q_valid (m_axis_tvalid),
        .q_data  (q_data),
        .q_ready (m_axis_tready),
        .q_count (q_count)
    );

    assign m_axis_tdata = {2'b00, q_data.flagged_first_byte, q_data.size_change,
                           q_data.out_byte};
    assign m_axis_tlast = q_data.out_last;
    assign m_axis_tuser = q_data.use_encoded;

    // packet end returns the coder to its idle state
    `ASSERT_NEXT(a_pkt_end_clears, clk, rst_n, fire && stg_last_reg,
        state_reg.run == 8'd0 && state_reg.net == '0 && state_reg.hdr_left == HDR_RESET)
    // an open run never holds a count past the close limit
    `ASSERT_IMPLIES(a_run_bounded, clk, rst_n, 1'b1, state_reg.run <= RUN_CLOSE_LIMIT)
    // summary fields appear on the packet's final word only
    `ASSERT_IMPLIES(a_summary_on_last, clk, rst_n, m_axis_tvalid && !m_axis_tlast,
        q_data.size_change == '0 && !q_data.use_encoded && q_data.flagged_first_byte == 8'd0)
    // encoded stream chosen only when it is strictly shorter
    `ASSERT_IMPLIES(a_choice_matches_size, clk, rst_n, m_axis_tvalid && m_axis_tlast,
        q_data.use_encoded == (q_data.size_change < 0))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the zero-run packet encoder: directed table and random packets.
`timescale 1ns / 1ps

module testbench;

    import zrpe_pkg::*;

    localparam int      RANDOM_WORDS = 550;
    localparam int      SETTLE       = 8;
    localparam int      CYCLE_LIMIT  = 1000000;
    localparam logic    CODING_OFF   = 1'b0;
    localparam logic    CODING_ON    = 1'b1;
    localparam result_t NO_WORD      = '0;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // One row of the directed plan; nlit > 0 means the expected words are typed in.
    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] val;
        logic       last;
        logic [1:0] nlit;
        result_t    lit0;
        result_t    lit1;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] in_byte
    logic        s_axis_tlast;     // in_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;     // [7:0] out_byte, [21:8] size_change,
                                   // [29:22] flagged_first_byte, [31:30] zero
    logic        m_axis_tlast;     // out_last
    logic        m_axis_tuser;     // use_encoded

    zero_run_packet_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Encoder mirror: register, per-packet latch and coder state.
    logic       coding_reg;
    logic       coding_pkt;
    logic [7:0] run_len;
    int         net;
    int         hdr_left;
    logic [7:0] first_byte;
    result_t    enc_out [2];
    int         enc_n;

    result_t    encoded_due [$];
    plan_row_t  plan [$];
    int         mismatches = 0;
    int         cycles = 0;
    int         send_idle;
    int         recv_idle;
    result_t    seen;
    result_t    want;

    function automatic result_t mk(input logic [7:0] b, input logic l, input logic u,
                                   input logic signed [NET_W-1:0] sc, input logic [7:0] f);
        result_t r;
        r.out_byte           = b;
        r.out_last           = l;
        r.use_encoded        = u;
        r.size_change        = sc;
        r.flagged_first_byte = f;
        return r;
    endfunction

    function automatic result_t plain(input logic [7:0] b);
        return mk(b, 1'b0, 1'b0, '0, '0);
    endfunction

    function automatic int clamp_net(input int v);
        if (v > int'(NET_MAX))
            return int'(NET_MAX);
        if (v < int'(NET_MIN))
            return int'(NET_MIN);
        return v;
    endfunction

    // Words caused by one accepted byte, left in enc_out[0 .. enc_n-1].
    task automatic encode_byte(input logic [7:0] b, input logic l);
        int sc;
        enc_n = 0;
        if (hdr_left == HEADER_BYTES)
        begin
            first_byte = b;
            coding_pkt = coding_reg;
        end
        if (hdr_left > 0)
        begin
            enc_out[enc_n] = plain(b);
            enc_n++;
            hdr_left--;
        end
        else if (!coding_pkt)
        begin
            enc_out[enc_n] = plain(b);
            enc_n++;
        end
        else if (b == 8'h00)
        begin
            if (run_len != 0)
            begin
                run_len++;
                // run hits 255: count goes out now
                if (run_len > RUN_CLOSE_LIMIT)
                begin
                    enc_out[enc_n] = plain(run_len);
                    enc_n++;
                    run_len = 0;
                end
                net = clamp_net(net - 1);
            end
            else
            begin
                enc_out[enc_n] = plain(8'h00);
                enc_n++;
                net = clamp_net(net + 1);
                run_len = 1;
            end
        end
        else
        begin
            if (run_len != 0)
            begin
                enc_out[enc_n] = plain(run_len);
                enc_n++;
                run_len = 0;
            end
            enc_out[enc_n] = plain(b);
            enc_n++;
        end
        if (l)
        begin
            // open run at packet end: count is the final word
            if (coding_pkt && run_len != 0)
            begin
                enc_out[enc_n] = plain(run_len);
                enc_n++;
            end
            sc = coding_pkt ? net : 0;
            enc_out[enc_n-1].out_last           = 1'b1;
            enc_out[enc_n-1].use_encoded        = (sc < 0);
            enc_out[enc_n-1].size_change        = NET_W'(sc);
            enc_out[enc_n-1].flagged_first_byte = first_byte | ZERO_FLAG_BIT;
            run_len  = 0;
            net      = 0;
            hdr_left = HEADER_BYTES;
        end
    endtask

    task automatic add_row(input row_kind_t k, input logic [7:0] v, input logic l,
                           input logic [1:0] n, input result_t e0, input result_t e1);
        plan_row_t r;
        r.kind = k;
        r.val  = v;
        r.last = l;
        r.nlit = n;
        r.lit0 = e0;
        r.lit1 = e1;
        plan.push_back(r);
    endtask

    // Drive one byte from a falling edge, hold until accepted, then log its words.
    task automatic send_byte(input logic [7:0] b, input logic l, input logic [1:0] nlit,
                             input result_t lit0, input result_t lit1);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        encode_byte(b, l);
        if (nlit == 0)
        begin
            for (int i = 0; i < enc_n; i++)
                encoded_due.push_back(enc_out[i]);
        end
        else
        begin
            encoded_due.push_back(lit0);
            if (nlit == 2)
                encoded_due.push_back(lit1);
        end
    endtask

    // Register write only with the block drained and quiet.
    task automatic write_coding(input logic v);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (encoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        coding_reg  = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver stalls change on the falling edge only.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.out_byte           = m_axis_tdata[7:0];
            seen.size_change        = m_axis_tdata[21:8];
            seen.flagged_first_byte = m_axis_tdata[29:22];
            seen.out_last           = m_axis_tlast;
            seen.use_encoded        = m_axis_tuser;
            if (encoded_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected byte %02h last %0b use %0b size %0d first %02h",
                         $time, seen.out_byte, seen.out_last, seen.use_encoded,
                         seen.size_change, seen.flagged_first_byte);
            end
            else
            begin
                want = encoded_due.pop_front();
                if (seen !== want || m_axis_tdata[31:30] !== 2'b00)
                begin
                    mismatches++;
                    $display("%0t: expected byte %02h last %0b use %0b size %0d first %02h",
                             $time, want.out_byte, want.out_last, want.use_encoded,
                             want.size_change, want.flagged_first_byte);
                    $display("%0t: actual byte %02h last %0b use %0b size %0d first %02h pad %0b",
                             $time, seen.out_byte, seen.out_last, seen.use_encoded,
                             seen.size_change, seen.flagged_first_byte, m_axis_tdata[31:30]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        int         sent;
        int         len;
        int         zl;
        int         i;
        logic       noise;
        logic [7:0] b;
        plan_row_t  row;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        send_idle     = 6;
        recv_idle     = 60;
        coding_reg    = 1'b0;
        coding_pkt    = 1'b0;
        run_len       = '0;
        net           = 0;
        hdr_left      = HEADER_BYTES;
        first_byte    = '0;

        // coding off after reset; packet ends inside the header
        add_row(ROW_WORD, 8'h00, 1'b0, 1, plain(8'h00), NO_WORD);
        add_row(ROW_WORD, 8'hFF, 1'b1, 1, mk(8'hFF, 1'b1, 1'b0, '0, 8'h80), NO_WORD);
        add_row(ROW_CFG, {7'd0, CODING_ON}, 1'b0, 0, NO_WORD, NO_WORD);
        // zero header bytes pass; runs of 3 and 2, the last one open at the end
        add_row(ROW_WORD, 8'h7F, 1'b0, 0, NO_WORD, NO_WORD);
        for (i = 0; i < 5; i++)
            add_row(ROW_WORD, 8'h00, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'hFF, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b1, 0, NO_WORD, NO_WORD);
        // coding on, packet ends inside the header
        add_row(ROW_WORD, 8'h01, 1'b0, 1, plain(8'h01), NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b0, 1, plain(8'h00), NO_WORD);
        add_row(ROW_WORD, 8'h80, 1'b1, 1, mk(8'h80, 1'b1, 1'b0, '0, 8'h81), NO_WORD);
        // single zero after the header, last: zero then count 1 from one byte
        add_row(ROW_WORD, 8'hAA, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h55, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'hFF, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h01, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'hFE, 1'b0, 0, NO_WORD, NO_WORD);
        add_row(ROW_WORD, 8'h00, 1'b1, 2, plain(8'h00), mk(8'h01, 1'b1, 1'b0, 14'sd1, 8'hAA));
        add_row(ROW_CFG, {7'd0, CODING_OFF}, 1'b0, 0, NO_WORD, NO_WORD);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            row = plan[k];
            if (row.kind == ROW_CFG)
                write_coding(row.val[0]);
            else
                send_byte(row.val, row.last, row.nlit, row.lit0, row.lit1);
        end

        // random packets: mostly well-formed header plus runs, some short noise
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent < RANDOM_WORDS / 3)
            begin
                send_idle = 6;
                recv_idle = 60;
            end
            else if (sent < 2 * RANDOM_WORDS / 3)
            begin
                send_idle = 60;
                recv_idle = 6;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if ($urandom_range(3) == 0)
                write_coding($urandom_range(3) != 0);
            noise = ($urandom_range(4) == 0);
            len = noise ? $urandom_range(1, HEADER_BYTES + 2)
                        : HEADER_BYTES + $urandom_range(1, 40);
            zl = 0;
            for (i = 0; i < len; i++)
            begin
                if (i < HEADER_BYTES || noise)
                    b = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
                else if (zl > 0)
                begin
                    b = 8'h00;
                    zl--;
                end
                else if ($urandom_range(2) == 0)
                begin
                    // start a zero run; now and then one long enough to close at 255
                    zl = ($urandom_range(59) == 0) ? $urandom_range(250, 262)
                                                   : $urandom_range(1, 6);
                    if (len < i + zl)
                        len = i + zl;
                    b = 8'h00;
                    zl--;
                end
                else
                    b = 8'($urandom_range(1, 255));
                send_byte(b, i == len - 1, 0, NO_WORD, NO_WORD);
                sent++;
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (encoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
